// File: hdl/lfc_pkg.sv
// ----------------------------------------------------------------------------
// lfc_pkg - shared types and constants of the link frame checker
// Frame summary and result types, register indexes, CRC-16 byte update.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned HDR_BYTES       = 12;
  localparam int unsigned MIN_FRAME       = 14;
  localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LEN_W           = CNT_W + 1;
  localparam int unsigned HDR_IDX_W       = $clog2(HDR_BYTES);
  localparam int unsigned FIFO_DEPTH      = 2;
  localparam int unsigned FIFO_AW         = $clog2(FIFO_DEPTH);
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 8;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] RST_CODE_TEXT   = 8'd0;
  localparam logic [7:0] RST_CODE_BINARY = 8'd1;
  localparam logic [7:0] RST_CODE_ACK    = 8'd2;
  localparam logic [7:0] RST_CODE_STREAM = 8'd3;
  localparam logic [3:0] RST_ACK_MASK    = 4'd1;
  localparam logic [3:0] HDR_VERSION     = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_TEXT   = 3'd0,
    CFG_CODE_BINARY = 3'd1,
    CFG_CODE_ACK    = 3'd2,
    CFG_CODE_STREAM = 3'd3,
    CFG_ACK_MASK    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_BAD_HDR = 2'd3
  } status_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // one finished frame as handed from front to back
  typedef struct packed {
    logic                           len_bad;
    logic                           crc_bad;
    logic [HDR_BYTES-1:0][7:0]      hdr;
    logic [7:0]                     plen;
  } frame_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  version;
    logic [3:0]  flag_bits;
    logic [7:0]  msg_type;
    logic [15:0] sequence_res;
    logic [31:0] source_id;
    logic [31:0] dest_id;
    logic [7:0]  body_len;
  } result_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/link_frame_checker_crc16_core.sv
// ----------------------------------------------------------------------------
// link_frame_checker_crc16_core - CRC-16 link frame checker
// Checks length, CRC-16 and header rules of byte-wise frames, one result
// per frame.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// input    | push / full        | data_byte_i, last_byte_i
// result   | empty / pop        | status_o .. body_len_o
// config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while full is low; the CRC byte update and
// header capture in the front stage set that figure. A result goes from the
// frame summary queue to the output register. Reset restores the type codes,
// ack mask and CRC state. The queue of two entries and the output register let
// intake and result side stall on their own; full rises only when both fill.
// ----------------------------------------------------------------------------
module link_frame_checker_crc16_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     status_o,
  output logic [3:0]                     version_o,
  output logic [3:0]                     flag_bits_o,
  output logic [7:0]                     msg_type_o,
  output logic [15:0]                    sequence_res_o,
  output logic [31:0]                    source_id_o,
  output logic [31:0]                    dest_id_o,
  output logic [7:0]                     body_len_o,
  input  logic                           cfg_we_i,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic             byte_valid;
  logic             frame_valid;
  lfc_pkg::frame_t  frame_in, frame_head;
  logic             q_full, q_empty, q_pop;
  logic             res_valid;
  lfc_pkg::result_t res;
  lfc_pkg::cfg_wr_t cfg;

  assign byte_valid = push && !q_full;
  assign full       = q_full;
  assign cfg.we     = cfg_we_i;
  assign cfg.idx    = cfg_idx_i;
  assign cfg.data   = cfg_wdata_i;

  lfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_valid),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame_in)
  );

  lfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_valid),
    .wdata_i (frame_in),
    .pop_i   (q_pop),
    .rdata_o (frame_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .frame_avail_i (!q_empty),
    .frame_i       (frame_head),
    .frame_take_o  (q_pop),
    .res_pop_i     (pop && res_valid),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign empty          = !res_valid;
  assign status_o       = res.status;
  assign version_o      = res.version;
  assign flag_bits_o    = res.flag_bits;
  assign msg_type_o     = res.msg_type;
  assign sequence_res_o = res.sequence_res;
  assign source_id_o    = res.source_id;
  assign dest_id_o      = res.dest_id;
  assign body_len_o     = res.body_len;

endmodule

// File: hdl/lfc_front.sv
// ----------------------------------------------------------------------------
// lfc_front - byte intake of the link frame checker
// Runs the CRC over the delayed bytes, counts length, captures the header and
// emits one frame summary on the last byte.
// ----------------------------------------------------------------------------
module lfc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  output logic            frame_valid_o,
  output lfc_pkg::frame_t frame_o
);

  logic [15:0]                 crc_q, crc_d;
  logic [lfc_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        too_long_q, too_long_d;
  logic [15:0]                 hold_q, hold_d;
  logic [lfc_pkg::HDR_BYTES-1:0][7:0] hdr_q;
  logic                        hdr_we;
  logic                        crc_en;
  logic [lfc_pkg::LEN_W-1:0]   len;
  logic [lfc_pkg::LEN_W-1:0]   plen_full;
  logic [lfc_pkg::LEN_W+7:0]   plen_ext;
  logic                        end_frame;

  assign end_frame = byte_valid_i && last_byte_i;
  assign hdr_we    = byte_valid_i && !too_long_q &&
                     (count_q < lfc_pkg::CNT_W'(lfc_pkg::HDR_BYTES));
  // the byte leaving the two-byte delay enters the CRC
  assign crc_en    = too_long_q || (count_q >= lfc_pkg::CNT_W'(2));
  assign hold_d    = {hold_q[7:0], data_byte_i};

  assign len       = {1'b0, count_q} + lfc_pkg::LEN_W'(1);
  assign plen_full = len - lfc_pkg::LEN_W'(lfc_pkg::MIN_FRAME);
  assign plen_ext  = {8'h00, plen_full};

  always_comb begin
    crc_d      = crc_q;
    count_d    = count_q;
    too_long_d = too_long_q;
    if (byte_valid_i) begin
      if (crc_en) begin
        crc_d = lfc_pkg::crc16_byte(crc_q, hold_q[15:8]);
      end
      if (last_byte_i) begin
        crc_d      = lfc_pkg::CRC_INIT;
        count_d    = '0;
        too_long_d = 1'b0;
      end else if (count_q >= lfc_pkg::CNT_W'(lfc_pkg::MAX_FRAME_BYTES)) begin
        too_long_d = 1'b1;
      end else begin
        count_d = count_q + lfc_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    frame_valid_o   = end_frame;
    frame_o.len_bad = too_long_q ||
                      (len < lfc_pkg::LEN_W'(lfc_pkg::MIN_FRAME)) ||
                      (len > lfc_pkg::LEN_W'(lfc_pkg::MAX_FRAME_BYTES));
    frame_o.crc_bad = hold_d != (crc_en ? lfc_pkg::crc16_byte(crc_q, hold_q[15:8]) : crc_q);
    frame_o.hdr     = hdr_q;
    frame_o.plen    = (plen_ext > (lfc_pkg::LEN_W + 8)'(255)) ? 8'hFF : plen_ext[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= lfc_pkg::CRC_INIT;
      count_q    <= '0;
      too_long_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      count_q    <= count_d;
      too_long_q <= too_long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      hold_q <= hold_d;
    end
    for (int i = 0; i < int'(lfc_pkg::HDR_BYTES); i++) begin
      if (hdr_we && (count_q[lfc_pkg::HDR_IDX_W-1:0] == lfc_pkg::HDR_IDX_W'(i))) begin
        hdr_q[i] <= data_byte_i;
      end
    end
  end

  a_too_long_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_long_q |-> count_q == lfc_pkg::CNT_W'(lfc_pkg::MAX_FRAME_BYTES))
    else $error("too_long set below saturated count");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_frame |=> (count_q == '0) && !too_long_q && (crc_q == lfc_pkg::CRC_INIT))
    else $error("frame state not cleared after last byte");

endmodule

// File: hdl/lfc_fifo.sv
// ----------------------------------------------------------------------------
// lfc_fifo - frame summary queue
// Short queue between byte intake and result stage.
// ----------------------------------------------------------------------------
module lfc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lfc_pkg::frame_t wdata_i,
  input  logic            pop_i,
  output lfc_pkg::frame_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  lfc_pkg::frame_t             mem_q [lfc_pkg::FIFO_DEPTH];
  logic [lfc_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [lfc_pkg::FIFO_AW:0]   cnt_q;
  logic                        do_push, do_pop;

  assign full_o  = cnt_q == (lfc_pkg::FIFO_AW + 1)'(lfc_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + lfc_pkg::FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + lfc_pkg::FIFO_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (lfc_pkg::FIFO_AW + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (lfc_pkg::FIFO_AW + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (lfc_pkg::FIFO_AW + 1)'(lfc_pkg::FIFO_DEPTH))
    else $error("frame queue count out of range");

endmodule

// File: hdl/lfc_back.sv
// ----------------------------------------------------------------------------
// lfc_back - result stage of the link frame checker
// Holds the type registers, applies version, type and ack rules, and keeps
// the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module lfc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lfc_pkg::cfg_wr_t cfg_i,
  input  logic             frame_avail_i,
  input  lfc_pkg::frame_t  frame_i,
  output logic             frame_take_o,
  input  logic             res_pop_i,
  output logic             res_valid_o,
  output lfc_pkg::result_t res_o
);

  logic [7:0]       code_text_q, code_binary_q, code_ack_q, code_stream_q;
  logic [3:0]       ack_mask_q;
  logic             valid_q;
  lfc_pkg::result_t res_q, res_d;
  logic             is_text, is_bin, is_ack, is_stream, flg_hit, hdr_bad;
  logic [7:0]       typ;
  logic [3:0]       ver, flg;

  assign typ       = frame_i.hdr[1];
  assign ver       = frame_i.hdr[0][7:4];
  assign flg       = frame_i.hdr[0][3:0];
  assign is_text   = typ == code_text_q;
  assign is_bin    = typ == code_binary_q;
  assign is_ack    = typ == code_ack_q;
  assign is_stream = typ == code_stream_q;
  assign flg_hit   = (flg & ack_mask_q) != 4'd0;
  assign hdr_bad   = (ver != lfc_pkg::HDR_VERSION) ||
                     !(is_text || is_bin || is_ack || is_stream) ||
                     (is_ack && ((frame_i.plen != 8'd0) || flg_hit)) ||
                     (is_stream && flg_hit);

  // advance when the output register is free or being emptied
  assign frame_take_o = frame_avail_i && (!valid_q || res_pop_i);
  assign res_valid_o  = valid_q;
  assign res_o        = res_q;

  always_comb begin
    res_d = '0;
    if (frame_i.len_bad) begin
      res_d.status = lfc_pkg::ST_BAD_LEN;
    end else if (frame_i.crc_bad) begin
      res_d.status = lfc_pkg::ST_BAD_CRC;
    end else begin
      res_d.status       = hdr_bad ? lfc_pkg::ST_BAD_HDR : lfc_pkg::ST_OK;
      res_d.version      = ver;
      res_d.flag_bits    = flg;
      res_d.msg_type     = typ;
      res_d.sequence_res = {frame_i.hdr[2], frame_i.hdr[3]};
      res_d.source_id    = {frame_i.hdr[4], frame_i.hdr[5], frame_i.hdr[6], frame_i.hdr[7]};
      res_d.dest_id      = {frame_i.hdr[8], frame_i.hdr[9], frame_i.hdr[10], frame_i.hdr[11]};
      res_d.body_len     = frame_i.plen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_text_q   <= lfc_pkg::RST_CODE_TEXT;
      code_binary_q <= lfc_pkg::RST_CODE_BINARY;
      code_ack_q    <= lfc_pkg::RST_CODE_ACK;
      code_stream_q <= lfc_pkg::RST_CODE_STREAM;
      ack_mask_q    <= lfc_pkg::RST_ACK_MASK;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        lfc_pkg::CFG_CODE_TEXT:   code_text_q   <= cfg_i.data;
        lfc_pkg::CFG_CODE_BINARY: code_binary_q <= cfg_i.data;
        lfc_pkg::CFG_CODE_ACK:    code_ack_q    <= cfg_i.data;
        lfc_pkg::CFG_CODE_STREAM: code_stream_q <= cfg_i.data;
        lfc_pkg::CFG_ACK_MASK:    ack_mask_q    <= cfg_i.data[3:0];
        default:                  ack_mask_q    <= ack_mask_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (frame_take_o) begin
      valid_q <= 1'b1;
    end else if (res_pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take_o) begin
      res_q <= res_d;
    end
  end

  a_bad_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ((res_q.status == lfc_pkg::ST_BAD_LEN) ||
                (res_q.status == lfc_pkg::ST_BAD_CRC))
    |-> (res_q.version == 4'd0) && (res_q.msg_type == 8'd0) &&
        (res_q.source_id == 32'd0) && (res_q.dest_id == 32'd0) &&
        (res_q.body_len == 8'd0))
    else $error("rejected frame carries header fields");

endmodule

// File: bench/link_frame_checker_crc16_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_frame_checker_crc16_core_tb - self-checking bench of the frame checker
// Feeds byte-wise frames through the push/full side and predicts one result
// per frame. Frames are either directed corner cases or random ones that are
// mostly well formed. Each popped result is checked field by field against
// the oldest prediction. The type codes and ack mask change between phases,
// and only while the block is idle. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module link_frame_checker_crc16_core_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } link_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte_i = 8'h00;
  logic last_byte_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status_o;
  logic [3:0] version_o;
  logic [3:0] flag_bits_o;
  logic [7:0] msg_type_o;
  logic [15:0] sequence_res_o;
  logic [31:0] source_id_o;
  logic [31:0] dest_id_o;
  logic [7:0] body_len_o;
  logic cfg_we_i = 1'b0;
  logic [lfc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  link_frame_checker_crc16_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .version_o      (version_o),
    .flag_bits_o    (flag_bits_o),
    .msg_type_o     (msg_type_o),
    .sequence_res_o (sequence_res_o),
    .source_id_o    (source_id_o),
    .dest_id_o      (dest_id_o),
    .body_len_o     (body_len_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  link_byte_t       link_bytes[$];
  lfc_pkg::result_t frame_verdicts[$];
  int unsigned      mismatches = 0;
  int unsigned      cycle_cnt = 0;
  bit               gaps_on = 1'b1;
  bit               byte_taken = 1'b0;
  bit               verdict_taken = 1'b0;
  int               byte_gap = 0;
  int               pop_gap = 0;

  // checker copy: registers and frame state
  logic [7:0]  m_code_text, m_code_bin, m_code_ack, m_code_stream;
  logic [3:0]  m_ack_mask;
  logic [15:0] m_crc;
  int unsigned m_count;
  logic [15:0] m_hold;
  logic [7:0]  m_hdr[lfc_pkg::HDR_BYTES];
  logic        m_over;

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? lfc_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic clear_frame_state();
    m_crc = lfc_pkg::CRC_INIT;
    m_count = 0;
    m_hold = 16'h0000;
    m_over = 1'b0;
    for (int i = 0; i < lfc_pkg::HDR_BYTES; i++) m_hdr[i] = 8'h00;
  endtask

  task automatic apply_reg(input logic [lfc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    case (idx)
      lfc_pkg::CFG_CODE_TEXT:   m_code_text = val;
      lfc_pkg::CFG_CODE_BINARY: m_code_bin = val;
      lfc_pkg::CFG_CODE_ACK:    m_code_ack = val;
      lfc_pkg::CFG_CODE_STREAM: m_code_stream = val;
      lfc_pkg::CFG_ACK_MASK:    m_ack_mask = val[3:0];
      default: ;
    endcase
  endtask

  // advance the frame state by one byte; predict the verdict on the last one
  task automatic frame_model_step(input logic [7:0] b, input logic lst);
    lfc_pkg::result_t res;
    int unsigned      len;
    int unsigned      plen;
    logic [3:0]       ver;
    logic [3:0]       flg;
    logic [7:0]       typ;
    logic             known;
    logic             bad;
    if (!m_over && m_count < lfc_pkg::HDR_BYTES) m_hdr[m_count] = b;
    if (m_over || m_count >= 2) m_crc = crc_next(m_crc, m_hold[15:8]);
    m_hold = {m_hold[7:0], b};
    if (!lst) begin
      if (m_count >= lfc_pkg::MAX_FRAME_BYTES) m_over = 1'b1;
      else m_count++;
      return;
    end
    res = '0;
    len = m_count + 1;
    if (m_over || len < lfc_pkg::MIN_FRAME || len > lfc_pkg::MAX_FRAME_BYTES) begin
      res.status = lfc_pkg::ST_BAD_LEN;
    end else if (m_hold != m_crc) begin
      res.status = lfc_pkg::ST_BAD_CRC;
    end else begin
      plen = len - lfc_pkg::MIN_FRAME;
      ver = m_hdr[0][7:4];
      flg = m_hdr[0][3:0];
      typ = m_hdr[1];
      known = (typ == m_code_text) || (typ == m_code_bin) ||
              (typ == m_code_ack) || (typ == m_code_stream);
      bad = (ver != lfc_pkg::HDR_VERSION) || !known;
      if (typ == m_code_ack && (plen != 0 || (flg & m_ack_mask) != 4'd0)) bad = 1'b1;
      if (typ == m_code_stream && (flg & m_ack_mask) != 4'd0) bad = 1'b1;
      res.status = bad ? lfc_pkg::ST_BAD_HDR : lfc_pkg::ST_OK;
      res.version = ver;
      res.flag_bits = flg;
      res.msg_type = typ;
      res.sequence_res = {m_hdr[2], m_hdr[3]};
      res.source_id = {m_hdr[4], m_hdr[5], m_hdr[6], m_hdr[7]};
      res.dest_id = {m_hdr[8], m_hdr[9], m_hdr[10], m_hdr[11]};
      res.body_len = (plen > 255) ? 8'hFF : plen[7:0];
    end
    frame_verdicts.push_back(res);
    clear_frame_state();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_verdict();
    lfc_pkg::result_t want;
    if (frame_verdicts.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d", $time, status_o);
      mismatches++;
      return;
    end
    want = frame_verdicts.pop_front();
    check_field("status", want.status, status_o);
    check_field("version", want.version, version_o);
    check_field("flag_bits", want.flag_bits, flag_bits_o);
    check_field("msg_type", want.msg_type, msg_type_o);
    check_field("sequence_res", want.sequence_res, sequence_res_o);
    check_field("source_id", want.source_id, source_id_o);
    check_field("dest_id", want.dest_id, dest_id_o);
    check_field("body_len", want.body_len, body_len_o);
  endtask

  // sample handshakes at the rising edge
  always @(posedge clk_i) begin
    byte_taken = 1'b0;
    verdict_taken = 1'b0;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_wdata_i);
      if (push && !full) begin
        byte_taken = 1'b1;
        frame_model_step(data_byte_i, last_byte_i);
      end
      if (pop && !empty) begin
        verdict_taken = 1'b1;
        check_verdict();
      end
    end
  end

  // byte driver: advance on an accepted transaction, hold otherwise
  always @(negedge clk_i) begin
    if (byte_taken) begin
      void'(link_bytes.pop_front());
      byte_gap = pick_gap();
    end
    if (!rst_ni || link_bytes.size() == 0) begin
      push <= 1'b0;
    end else if (byte_gap > 0) begin
      byte_gap--;
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      data_byte_i <= link_bytes[0].data;
      last_byte_i <= link_bytes[0].last;
    end
  end

  // result side: stall at random between transactions
  always @(negedge clk_i) begin
    if (verdict_taken) pop_gap = pick_gap();
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic write_reg(input lfc_pkg::cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (link_bytes.size() != 0 || frame_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_codes(input logic [7:0] t, input logic [7:0] b, input logic [7:0] a,
                           input logic [7:0] s, input logic [3:0] m);
    wait_idle();
    write_reg(lfc_pkg::CFG_CODE_TEXT, t);
    write_reg(lfc_pkg::CFG_CODE_BINARY, b);
    write_reg(lfc_pkg::CFG_CODE_ACK, a);
    write_reg(lfc_pkg::CFG_CODE_STREAM, s);
    // upper bits of the mask write are don't care
    write_reg(lfc_pkg::CFG_ACK_MASK, {4'($urandom), m});
  endtask

  // build one frame; fill < 0 means random header tail and payload
  task automatic queue_frame(input logic [7:0] vf, input logic [7:0] typ, input int total,
                             input bit crc_ok, input int fill);
    logic [7:0]  body[$];
    logic [15:0] c;
    int          n;
    link_byte_t  it;
    n = (total >= 2) ? total - 2 : total;
    for (int i = 0; i < n; i++) begin
      if (i == 0) body.push_back(vf);
      else if (i == 1) body.push_back(typ);
      else body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
    if (total >= 2) begin
      c = lfc_pkg::CRC_INIT;
      foreach (body[i]) c = crc_next(c, body[i]);
      if (!crc_ok) c ^= 16'h0001 << $urandom_range(0, 15);
      body.push_back(c[15:8]);
      body.push_back(c[7:0]);
    end
    foreach (body[i]) begin
      it.data = body[i];
      it.last = (i == body.size() - 1);
      link_bytes.push_back(it);
    end
  endtask

  task automatic random_frames(input int n_bytes);
    int         added;
    int         frames;
    int         r;
    int         total;
    logic [3:0] ver;
    logic [3:0] flg;
    logic [7:0] typ;
    added = 0;
    frames = 0;
    while (added < n_bytes || frames < 3) begin
      r = $urandom_range(0, 99);
      if (r < 8) total = $urandom_range(1, 13);
      else if (r < 11) total = $urandom_range(lfc_pkg::MAX_FRAME_BYTES + 1,
                                              lfc_pkg::MAX_FRAME_BYTES + 64);
      else if (r < 20) total = $urandom_range(31, lfc_pkg::MAX_FRAME_BYTES);
      else total = $urandom_range(lfc_pkg::MIN_FRAME, 30);
      ver = ($urandom_range(0, 99) < 85) ? lfc_pkg::HDR_VERSION : 4'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 3))
          0: typ = m_code_text;
          1: typ = m_code_bin;
          2: typ = m_code_ack;
          default: typ = m_code_stream;
        endcase
      end else begin
        typ = 8'($urandom);
      end
      flg = 4'($urandom);
      if ((typ == m_code_ack || typ == m_code_stream) && $urandom_range(0, 1))
        flg &= ~m_ack_mask;
      if (typ == m_code_ack && $urandom_range(0, 1)) total = lfc_pkg::MIN_FRAME;
      queue_frame({ver, flg}, typ, total, $urandom_range(0, 99) < 90, -1);
      added += total;
      frames++;
    end
  endtask

  initial begin
    m_code_text = lfc_pkg::RST_CODE_TEXT;
    m_code_bin = lfc_pkg::RST_CODE_BINARY;
    m_code_ack = lfc_pkg::RST_CODE_ACK;
    m_code_stream = lfc_pkg::RST_CODE_STREAM;
    m_ack_mask = lfc_pkg::RST_ACK_MASK;
    clear_frame_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner cases under reset codes
    queue_frame(8'h10, lfc_pkg::RST_CODE_TEXT, lfc_pkg::MIN_FRAME, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_BINARY, lfc_pkg::MAX_FRAME_BYTES, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_TEXT, lfc_pkg::MIN_FRAME - 1, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_TEXT, 1, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_TEXT, 2, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_BINARY, lfc_pkg::MAX_FRAME_BYTES + 1, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_BINARY, 600, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_BINARY, 20, 1'b0, -1);
    queue_frame(8'h00, lfc_pkg::RST_CODE_TEXT, lfc_pkg::MIN_FRAME, 1'b1, -1);
    queue_frame(8'hF0, lfc_pkg::RST_CODE_TEXT, lfc_pkg::MIN_FRAME, 1'b1, -1);
    queue_frame(8'h1F, 8'hFF, 15, 1'b1, 8'hFF);
    queue_frame(8'h10, lfc_pkg::RST_CODE_ACK, lfc_pkg::MIN_FRAME, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_ACK, 15, 1'b1, -1);
    queue_frame(8'h11, lfc_pkg::RST_CODE_ACK, lfc_pkg::MIN_FRAME, 1'b1, -1);
    queue_frame(8'h1E, lfc_pkg::RST_CODE_ACK, lfc_pkg::MIN_FRAME, 1'b1, -1);
    queue_frame(8'h11, lfc_pkg::RST_CODE_STREAM, 30, 1'b1, -1);
    queue_frame(8'h1E, lfc_pkg::RST_CODE_STREAM, 30, 1'b1, -1);
    queue_frame(8'h10, lfc_pkg::RST_CODE_TEXT, lfc_pkg::MIN_FRAME, 1'b1, 0);
    queue_frame(8'h10, lfc_pkg::RST_CODE_BINARY, lfc_pkg::MIN_FRAME, 1'b0, 8'hFF);
    random_frames(120);

    // extreme codes, full mask, no idling
    set_codes(8'hFF, 8'h00, 8'h80, 8'h7F, 4'hF);
    gaps_on = 1'b0;
    random_frames(120);
    gaps_on = 1'b1;

    // all codes equal: every rule hits one type
    set_codes(8'h5A, 8'h5A, 8'h5A, 8'h5A, 4'h0);
    random_frames(120);

    // ack and stream share a code
    set_codes(8'h21, 8'h42, 8'h99, 8'h99, 4'h8);
    random_frames(120);

    set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              4'($urandom_range(1, 15)));
    random_frames(120);

    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
